// ===== rtl/itp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itp_pkg
// Shared constants and character classification for the infix to postfix
// converter.
// ----------------------------------------------------------------------------
package itp_pkg;

    localparam int unsigned STACK_DEPTH_DEF = 32;
    localparam int unsigned CHAR_W          = 8;

    typedef logic [CHAR_W-1:0] t_char;
    typedef logic [1:0]        t_prec;

    localparam t_char C_PLUS  = 8'h2B;
    localparam t_char C_MINUS = 8'h2D;
    localparam t_char C_STAR  = 8'h2A;
    localparam t_char C_SLASH = 8'h2F;
    localparam t_char C_CARET = 8'h5E;
    localparam t_char C_LPAR  = 8'h28;
    localparam t_char C_RPAR  = 8'h29;
    localparam t_char C_NUL   = 8'h00;

    localparam t_prec P_ADD   = 2'd1;
    localparam t_prec P_MUL   = 2'd2;
    localparam t_prec P_POW   = 2'd3;
    localparam t_prec P_OTHER = 2'd0;

    function automatic t_prec prec_of(input t_char c);
        t_prec p;
        if (c == C_PLUS || c == C_MINUS) begin
            p = P_ADD;
        end else if (c == C_STAR || c == C_SLASH) begin
            p = P_MUL;
        end else if (c == C_CARET) begin
            p = P_POW;
        end else begin
            p = P_OTHER;
        end
        return p;
    endfunction

    function automatic logic is_alnum(input t_char c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h61 && c <= 8'h7A);
    endfunction

endpackage

// ===== rtl/itp_stack.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itp_stack
// Operator stack storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module itp_stack
    import itp_pkg::*;
#(
    parameter int unsigned DEPTH = STACK_DEPTH_DEF,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_char         i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_char         o_rdata
);

    t_char r_mem [0:DEPTH-1];
    t_char r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/infix_to_postfix_converter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// infix_to_postfix_converter
// Shunting-yard converter: one character in, zero or more postfix symbols out.
// ----------------------------------------------------------------------------
//  channel  direction  handshake          payload
//  input    in         i_valid / o_ready  i_in_char, i_end_of_expr
//  result   out        o_valid / i_ready  o_out_char, o_last_of_run,
//                                         o_is_terminator, o_overflow_seen
//
//  Each item passes through S_TEST, and through S_FLUSH if it emits; every
//  emitting pop is followed by S_FETCH, as it waits on the stack read port.
//  A full output register stalls the sequencer until the result transfers.
//  Reset is synchronous, active low; it empties the stack and clears the
//  overflow flag. o_ready is high only while no item is in progress.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter
    import itp_pkg::*;
#(
    parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_char i_in_char,
    input  logic  i_end_of_expr,
    output logic  o_valid,
    input  logic  i_ready,
    output t_char o_out_char,
    output logic  o_last_of_run,
    output logic  o_is_terminator,
    output logic  o_overflow_seen
);

    localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
    localparam int unsigned AW = $clog2(STACK_DEPTH);

    typedef enum logic [1:0] {S_IDLE, S_TEST, S_FETCH, S_FLUSH} t_state;
    typedef enum logic [2:0] {M_ALNUM, M_OPEN, M_CLOSE, M_OP, M_END} t_mode;

    t_state r_state, n_state;
    t_mode  r_mode,  n_mode;
    t_char  r_char,  n_char;
    logic [CW-1:0] r_count, n_count;
    logic   r_ovf, n_ovf;

    logic   r_pend_valid, n_pend_valid;
    t_char  r_pend_char,  n_pend_char;
    logic   r_pend_term,  n_pend_term;
    logic   r_pend_ovf,   n_pend_ovf;

    logic   r_out_valid, n_out_valid;
    t_char  r_out_char,  n_out_char;
    logic   r_out_last,  n_out_last;
    logic   r_out_term,  n_out_term;
    logic   r_out_ovf,   n_out_ovf;

    t_char         w_top;
    logic          w_we;
    logic [AW-1:0] w_raddr;
    logic          w_slot_free;
    logic          w_has_top;
    logic          w_emit, w_pop, w_push, w_done, w_stall;
    t_char         w_e_char;
    logic          w_e_term;

    assign w_raddr = AW'(r_count - CW'(1));

    itp_stack #(
        .DEPTH (STACK_DEPTH),
        .AW    (AW)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (r_char),
        .i_raddr (w_raddr),
        .o_rdata (w_top)
    );

    assign w_slot_free = !r_out_valid || i_ready;
    assign w_has_top   = r_count != '0;

    always_comb begin
        w_emit   = 1'b0;
        w_pop    = 1'b0;
        w_push   = 1'b0;
        w_done   = 1'b0;
        w_e_char = r_char;
        w_e_term = 1'b0;
        unique case (r_mode)
            M_ALNUM: begin
                w_emit = 1'b1;
                w_done = 1'b1;
            end
            M_OPEN: begin
                w_push = 1'b1;
                w_done = 1'b1;
            end
            M_CLOSE: begin
                if (w_has_top && w_top != C_LPAR) begin
                    w_emit   = 1'b1;
                    w_pop    = 1'b1;
                    w_e_char = w_top;
                end else begin
                    w_pop  = w_has_top;
                    w_done = 1'b1;
                end
            end
            M_OP: begin
                if (w_has_top && prec_of(r_char) <= prec_of(w_top)) begin
                    w_emit   = 1'b1;
                    w_pop    = 1'b1;
                    w_e_char = w_top;
                end else begin
                    w_push = 1'b1;
                    w_done = 1'b1;
                end
            end
            M_END: begin
                w_emit = 1'b1;
                if (w_has_top) begin
                    w_pop    = 1'b1;
                    w_e_char = w_top;
                end else begin
                    w_e_char = C_NUL;
                    w_e_term = 1'b1;
                    w_done   = 1'b1;
                end
            end
            default: begin
                w_done = 1'b1;
            end
        endcase
        w_stall = w_emit && r_pend_valid && !w_slot_free;
    end

    assign w_we = (r_state == S_TEST) && !w_stall && w_push &&
                  (r_count < CW'(STACK_DEPTH));

    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_char       = r_char;
        n_count      = r_count;
        n_ovf        = r_ovf;
        n_pend_valid = r_pend_valid;
        n_pend_char  = r_pend_char;
        n_pend_term  = r_pend_term;
        n_pend_ovf   = r_pend_ovf;
        n_out_valid  = r_out_valid && !i_ready;
        n_out_char   = r_out_char;
        n_out_last   = r_out_last;
        n_out_term   = r_out_term;
        n_out_ovf    = r_out_ovf;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_char  = i_in_char;
                    n_state = S_TEST;
                    priority if (i_end_of_expr) begin
                        n_mode = M_END;
                    end else if (is_alnum(i_in_char)) begin
                        n_mode = M_ALNUM;
                    end else if (i_in_char == C_LPAR) begin
                        n_mode = M_OPEN;
                    end else if (i_in_char == C_RPAR) begin
                        n_mode = M_CLOSE;
                    end else begin
                        n_mode = M_OP;
                    end
                end
            end
            S_TEST: begin
                if (!w_stall) begin
                    if (w_pop) begin
                        n_count = r_count - CW'(1);
                    end
                    if (w_push) begin
                        if (r_count < CW'(STACK_DEPTH)) begin
                            n_count = r_count + CW'(1);
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end
                    if (w_emit) begin
                        if (r_pend_valid) begin
                            n_out_valid = 1'b1;
                            n_out_char  = r_pend_char;
                            n_out_last  = 1'b0;
                            n_out_term  = r_pend_term;
                            n_out_ovf   = r_pend_ovf;
                        end
                        n_pend_valid = 1'b1;
                        n_pend_char  = w_e_char;
                        n_pend_term  = w_e_term;
                        n_pend_ovf   = w_e_term && r_ovf;
                        if (w_e_term) begin
                            n_ovf = 1'b0;
                        end
                    end
                    if (!w_done) begin
                        n_state = S_FETCH;
                    end else if (w_emit || r_pend_valid) begin
                        n_state = S_FLUSH;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_FETCH: begin
                n_state = S_TEST;
            end
            S_FLUSH: begin
                if (w_slot_free) begin
                    n_out_valid  = 1'b1;
                    n_out_char   = r_pend_char;
                    n_out_last   = 1'b1;
                    n_out_term   = r_pend_term;
                    n_out_ovf    = r_pend_ovf;
                    n_pend_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_mode       <= M_ALNUM;
            r_count      <= '0;
            r_ovf        <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_mode       <= n_mode;
            r_count      <= n_count;
            r_ovf        <= n_ovf;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
        r_char      <= n_char;
        r_pend_char <= n_pend_char;
        r_pend_term <= n_pend_term;
        r_pend_ovf  <= n_pend_ovf;
        r_out_char  <= n_out_char;
        r_out_last  <= n_out_last;
        r_out_term  <= n_out_term;
        r_out_ovf   <= n_out_ovf;
    end

    assign o_ready         = r_state == S_IDLE;
    assign o_valid         = r_out_valid;
    assign o_out_char      = r_out_char;
    assign o_last_of_run   = r_out_last;
    assign o_is_terminator = r_out_term;
    assign o_overflow_seen = r_out_ovf;

endmodule

// ===== rtl/itp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itp_checker
// Port-level checks on the converter, bound to the top level.
// ----------------------------------------------------------------------------
module itp_checker
    import itp_pkg::*;
(
    input logic  i_clk,
    input logic  i_rst_n,
    input logic  i_valid,
    input logic  o_ready,
    input logic  o_valid,
    input logic  i_ready,
    input t_char o_out_char,
    input logic  o_last_of_run,
    input logic  o_is_terminator,
    input logic  o_overflow_seen
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_char) &&
            $stable(o_last_of_run) && $stable(o_is_terminator))
        else $error("stalled result changed");

    a_term_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_terminator |-> o_last_of_run && o_out_char == C_NUL)
        else $error("terminator not last or carries a symbol");

    a_sym_no_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_is_terminator |-> !o_overflow_seen)
        else $error("overflow reported on a symbol");

    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("ready held after an input transfer");

endmodule

bind infix_to_postfix_converter itp_checker u_itp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_ready         (o_ready),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_out_char      (o_out_char),
    .o_last_of_run   (o_last_of_run),
    .o_is_terminator (o_is_terminator),
    .o_overflow_seen (o_overflow_seen)
);
